### hw/rtl/refcounted_two_pool_buffer_allocator_defines.svh
// assertion macros shared by the allocator rtl
`ifndef REFCOUNTED_TWO_POOL_BUFFER_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_TWO_POOL_BUFFER_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define RCPOOL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define RCPOOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rcpool_pkg.sv
// types and codes of the two-pool reference-counted buffer allocator
package rcpool_pkg;

  localparam logic [1:0] OP_ALLOC_TX = 2'd0;
  localparam logic [1:0] OP_ALLOC_RX = 2'd1;
  localparam logic [1:0] OP_ADD_REF  = 2'd2;
  localparam logic [1:0] OP_DROP_REF = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] handle;
  } req_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] granted_handle;
    logic       returned_to_pool;
    logic [4:0] tx_free_count;
    logic [4:0] rx_free_count;
  } rsp_word_t;

  typedef enum logic [2:0] {
    KIND_ALLOC_TX = 3'd0,
    KIND_ALLOC_RX = 3'd1,
    KIND_ADD      = 3'd2,
    KIND_DROP     = 3'd3,
    KIND_BAD      = 3'd4
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [4:0] handle;
    logic       is_rx;
  } job_t;

endpackage

### hw/rtl/rcpool_queue.sv
// two-entry job queue between the classifier and the executor
module rcpool_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rcpool_pkg::job_t  push_job,
  output logic              space,
  input  logic              pop,
  output logic              head_valid,
  output rcpool_pkg::job_t  head_job
);
  import rcpool_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  logic do_push;
  logic do_pop;

  assign space      = (fill != DEPTH);
  assign head_valid = (fill != 2'd0);
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && space;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hw/rtl/rcpool_front.sv
// request intake: classifies each word by op and handle range
module rcpool_front #(
  parameter int TX_ENTRIES = 16,
  parameter int RX_ENTRIES = 16
) (
  input  logic                  req_valid,
  output logic                  req_ready,
  input  rcpool_pkg::req_word_t req_word,
  input  logic                  clearing,
  input  logic                  q_space,
  output logic                  q_push,
  output rcpool_pkg::job_t      q_job
);
  import rcpool_pkg::*;

  localparam int TOTAL = TX_ENTRIES + RX_ENTRIES;

  logic [31:0] h32;

  assign h32       = 32'(req_word.handle);
  assign req_ready = q_space && !clearing;
  assign q_push    = req_valid && req_ready;

  always_comb begin
    q_job.handle = req_word.handle;
    q_job.is_rx  = (h32 >= 32'(TX_ENTRIES));
    case (req_word.op)
      OP_ALLOC_TX: q_job.kind = KIND_ALLOC_TX;
      OP_ALLOC_RX: q_job.kind = KIND_ALLOC_RX;
      OP_ADD_REF:  q_job.kind = (h32 >= 32'(TOTAL)) ? KIND_BAD : KIND_ADD;
      OP_DROP_REF: q_job.kind = (h32 >= 32'(TOTAL)) ? KIND_BAD : KIND_DROP;
      default:     q_job.kind = KIND_BAD;
    endcase
  end

endmodule

### hw/rtl/rcpool_back.sv
// executor: free stacks, reference counts and the response register
module rcpool_back #(
  parameter int TX_ENTRIES  = 16,
  parameter int RX_ENTRIES  = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  rcpool_pkg::job_t      q_job,
  output logic                  q_pop,
  output logic                  clearing,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rcpool_pkg::rsp_word_t rsp_word
);
  import rcpool_pkg::*;
  `include "refcounted_two_pool_buffer_allocator_defines.svh"

  localparam int TOTAL = TX_ENTRIES + RX_ENTRIES;
  localparam int TXW   = (TX_ENTRIES > 1) ? $clog2(TX_ENTRIES) : 1;
  localparam int RXW   = (RX_ENTRIES > 1) ? $clog2(RX_ENTRIES) : 1;
  localparam int HW    = $clog2(TOTAL);
  localparam int TXCW  = $clog2(TX_ENTRIES + 1);
  localparam int RXCW  = $clog2(RX_ENTRIES + 1);
  localparam logic [COUNT_WIDTH-1:0] RC_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_READ  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [TXW-1:0]         tx_stack [TX_ENTRIES];
  logic [RXW-1:0]         rx_stack [RX_ENTRIES];
  logic [COUNT_WIDTH-1:0] refcnt   [TOTAL];

  logic [TXCW-1:0]        tx_cnt;
  logic [TXCW-1:0]        tx_cnt_next;
  logic [RXCW-1:0]        rx_cnt;
  logic [RXCW-1:0]        rx_cnt_next;
  logic [HW-1:0]          clr_idx;

  logic [TXW-1:0]         tx_rd;
  logic [RXW-1:0]         rx_rd;
  logic [COUNT_WIDTH-1:0] rc_rd;

  logic [HW-1:0]          hidx;
  logic                   out_free;
  logic                   fire;

  logic                   rc_we;
  logic [HW-1:0]          rc_wa;
  logic [COUNT_WIDTH-1:0] rc_wd;
  logic                   tx_we;
  logic [TXW-1:0]         tx_wa;
  logic [TXW-1:0]         tx_wd;
  logic                   rx_we;
  logic [RXW-1:0]         rx_wa;
  logic [RXW-1:0]         rx_wd;

  rsp_word_t              rsp_next;

  assign hidx     = HW'(q_job.handle);
  assign out_free = !rsp_valid || rsp_ready;
  assign fire     = (state == S_EXEC) && out_free;
  assign q_pop    = fire;
  assign clearing = (state == S_CLEAR);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (32'(clr_idx) == 32'(TOTAL - 1)) state_next = S_READ;
      S_READ:  if (q_valid) state_next = S_EXEC;
      S_EXEC:  if (out_free) state_next = S_READ;
      default: state_next = S_CLEAR;
    endcase
  end

  // one job's effect on stacks, counts and the response
  always_comb begin
    rsp_next.status           = ST_OK;
    rsp_next.granted_handle   = 5'd0;
    rsp_next.returned_to_pool = 1'b0;
    tx_cnt_next = tx_cnt;
    rx_cnt_next = rx_cnt;
    rc_we = 1'b0;
    rc_wa = hidx;
    rc_wd = '0;
    tx_we = 1'b0;
    tx_wa = TXW'(tx_cnt);
    tx_wd = TXW'(q_job.handle);
    rx_we = 1'b0;
    rx_wa = RXW'(rx_cnt);
    rx_wd = RXW'(32'(q_job.handle) - 32'(TX_ENTRIES));
    case (q_job.kind)
      KIND_ALLOC_TX: begin
        if (tx_cnt == '0) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          tx_cnt_next = tx_cnt - TXCW'(1);
          rc_we = 1'b1;
          rc_wa = HW'(tx_rd);
          rc_wd = COUNT_WIDTH'(1);
          rsp_next.granted_handle = 5'(tx_rd);
        end
      end
      KIND_ALLOC_RX: begin
        if (rx_cnt == '0) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rx_cnt_next = rx_cnt - RXCW'(1);
          rc_we = 1'b1;
          rc_wa = HW'(32'(TX_ENTRIES) + 32'(rx_rd));
          rc_wd = COUNT_WIDTH'(1);
          rsp_next.granted_handle = 5'(32'(TX_ENTRIES) + 32'(rx_rd));
        end
      end
      KIND_ADD: begin
        if (rc_rd == '0) begin
          rsp_next.status = ST_ZERO;
        end else if (rc_rd == RC_MAX) begin
          rsp_next.status = ST_SAT;
        end else begin
          rc_we = 1'b1;
          rc_wd = rc_rd + COUNT_WIDTH'(1);
        end
      end
      KIND_DROP: begin
        if (rc_rd == '0) begin
          rsp_next.status = ST_ZERO;
        end else begin
          rc_we = 1'b1;
          rc_wd = rc_rd - COUNT_WIDTH'(1);
          if (rc_rd == COUNT_WIDTH'(1)) begin
            rsp_next.returned_to_pool = 1'b1;
            if (!q_job.is_rx) begin
              if (32'(tx_cnt) < 32'(TX_ENTRIES)) begin
                tx_we = 1'b1;
                tx_cnt_next = tx_cnt + TXCW'(1);
              end
            end else begin
              if (32'(rx_cnt) < 32'(RX_ENTRIES)) begin
                rx_we = 1'b1;
                rx_cnt_next = rx_cnt + RXCW'(1);
              end
            end
          end
        end
      end
      default: rsp_next.status = ST_ZERO;
    endcase
    rsp_next.tx_free_count = 5'(tx_cnt_next);
    rsp_next.rx_free_count = 5'(rx_cnt_next);
  end

  // memories: registered reads in the read step, writes on execute or clear
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      tx_rd <= tx_stack[TXW'(tx_cnt - TXCW'(1))];
      rx_rd <= rx_stack[RXW'(rx_cnt - RXCW'(1))];
      rc_rd <= refcnt[hidx];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (32'(clr_idx) < 32'(TX_ENTRIES)) begin
        tx_stack[TXW'(clr_idx)] <= TXW'(clr_idx);
      end
    end else if (fire && tx_we) begin
      tx_stack[tx_wa] <= tx_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (32'(clr_idx) < 32'(RX_ENTRIES)) begin
        rx_stack[RXW'(clr_idx)] <= RXW'(clr_idx);
      end
    end else if (fire && rx_we) begin
      rx_stack[rx_wa] <= rx_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      refcnt[clr_idx] <= '0;
    end else if (fire && rc_we) begin
      refcnt[rc_wa] <= rc_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_word <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      tx_cnt    <= TXCW'(TX_ENTRIES);
      rx_cnt    <= RXCW'(RX_ENTRIES);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + HW'(1);
      end
      if (fire) begin
        tx_cnt    <= tx_cnt_next;
        rx_cnt    <= rx_cnt_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `RCPOOL_ASSERT_NEXT(a_read_to_exec, (state == S_READ) && q_valid, state == S_EXEC,
    "job fetched but executor did not move to execute")

  `RCPOOL_ASSERT_NEXT(a_tx_alloc_pops,
    fire && (q_job.kind == KIND_ALLOC_TX) && (tx_cnt != '0),
    tx_cnt == $past(tx_cnt) - TXCW'(1), "transmit allocation did not pop one entry")

  `RCPOOL_ASSERT_NEXT(a_tx_release_pushes,
    fire && (q_job.kind == KIND_DROP) && !q_job.is_rx && (rc_rd == COUNT_WIDTH'(1))
      && (32'(tx_cnt) < 32'(TX_ENTRIES)),
    tx_cnt == $past(tx_cnt) + TXCW'(1), "released transmit buffer was not pushed")

  `RCPOOL_ASSERT_NEXT(a_fire_gives_rsp, fire, rsp_valid,
    "executed job left no response")

endmodule

### hw/rtl/refcounted_two_pool_buffer_allocator.sv
// top level of the two-pool reference-counted buffer allocator
//
// request channel req_valid/req_ready/req_word carries one op word: allocate
// transmit, allocate receive, add reference or drop reference on a handle.
// response channel rsp_valid/rsp_ready/rsp_word returns exactly one word per
// request, in order: status, granted handle, release flag and both free counts.
// a front stage classifies each word by op and handle range and places it in a
// two-entry queue; the back stage runs one job at a time: a registered read of
// the free stacks and reference counts, then the update. after rst the back
// stage sweeps all TX_ENTRIES + RX_ENTRIES entries, one a cycle, reloading
// both stacks with the highest index on top and zeroing the counts; req_ready
// stays low during the sweep.
// when the receiver stalls the response register holds its word, the executor
// waits behind it and the queue keeps taking requests until it is full
module refcounted_two_pool_buffer_allocator #(
  parameter int TX_ENTRIES  = 16,
  parameter int RX_ENTRIES  = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  rcpool_pkg::req_word_t req_word,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rcpool_pkg::rsp_word_t rsp_word
);
  import rcpool_pkg::*;

  // front to queue
  logic q_space;
  logic q_push;
  job_t q_job_in;

  // queue to back
  logic q_valid;
  logic q_pop;
  job_t q_head;

  // reset sweep in progress, holds off intake
  logic clearing;

  rcpool_front #(
    .TX_ENTRIES (TX_ENTRIES),
    .RX_ENTRIES (RX_ENTRIES)
  ) u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .clearing  (clearing),
    .q_space   (q_space),
    .q_push    (q_push),
    .q_job     (q_job_in)
  );

  rcpool_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job_in),
    .space      (q_space),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head)
  );

  rcpool_back #(
    .TX_ENTRIES  (TX_ENTRIES),
    .RX_ENTRIES  (RX_ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

endmodule
